/* hw/rtl/bgp_pkg.sv */
// Shared types and constants of the piecewise battery gauge.
package bgp_pkg;

  localparam int TIME_W = 32;
  localparam int INTERVAL_W = 31;
  localparam int MV_W = 13;
  localparam int PCT_W = 7;
  localparam int QUO_W = 7;
  localparam int NUM_W = MV_W + PCT_W;
  localparam int CFG_IDX_W = 8;
  localparam int MAX_BP = 16;

  localparam logic [MV_W-1:0] FULL_SCALE_MV = 13'd6600;
  localparam logic [MV_W-1:0] RESET_FULL_MV = 13'd4200;
  localparam logic [MV_W-1:0] RESET_EMPTY_MV = 13'd3400;
  localparam logic [MV_W-1:0] RESET_LOW_MV = 13'd3680;
  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 31'd600000;
  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  typedef logic [MV_W-1:0] mv_t;
  typedef logic [PCT_W-1:0] pct_t;

  localparam mv_t INTERIOR_MV [MAX_BP] = '{
    13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820, 13'd3790, 13'd3770, 13'd3740,
    13'd3680, 13'd3680, 13'd3680, 13'd3680, 13'd3680, 13'd3680, 13'd3680, 13'd3680
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_INTERVAL = 8'd0,
    CFG_LOW_THRESHOLD  = 8'd1,
    CFG_FULL           = 8'd2,
    CFG_EMPTY          = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic measured;
    mv_t  voltage;
  } sample_t;

  typedef struct packed {
    sample_t smp;
    pct_t    base_pct;
    mv_t     delta;
    pct_t    step_pct;
    mv_t     span;
  } seg_t;

  typedef struct packed {
    sample_t          smp;
    pct_t             base_pct;
    logic [NUM_W-1:0] rem;
    mv_t              span;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

/* hw/rtl/bgp_front.sv */
// Input register, check-time compare and sample to millivolt conversion.
module bgp_front #(
  parameter int ADC_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bgp_pkg::TIME_W-1:0]           now_time,
  input  logic [ADC_BITS-1:0]                  adc_sample,
  input  logic [bgp_pkg::INTERVAL_W-1:0]       check_interval,
  output logic                                 o_valid,
  input  logic                                 o_ready,
  output bgp_pkg::sample_t                     o_data
);

  localparam int PROD_W = ADC_BITS + bgp_pkg::MV_W;

  logic                        v0;
  logic [bgp_pkg::TIME_W-1:0]  now_q;
  logic [ADC_BITS-1:0]         adc_q;
  logic [bgp_pkg::TIME_W-1:0]  next_check;
  logic                        s1_ready;
  logic                        move0;
  logic                        take;
  logic [PROD_W-1:0]           prod;
  logic [bgp_pkg::TIME_W-1:0]  next_check_next;

  assign s1_ready = !o_valid || o_ready;
  assign in_ready = !v0 || s1_ready;
  assign move0 = v0 && s1_ready;
  assign take = now_q > next_check;
  assign prod = PROD_W'(adc_q) * PROD_W'(bgp_pkg::FULL_SCALE_MV);
  assign next_check_next = now_q + bgp_pkg::TIME_W'(check_interval);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      o_valid <= 1'b0;
      next_check <= '0;
    end else begin
      if (in_ready) begin
        v0 <= in_valid;
      end
      if (s1_ready) begin
        o_valid <= v0;
      end
      if (move0 && take) begin
        next_check <= next_check_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_q <= now_time;
      adc_q <= adc_sample;
    end
    if (move0) begin
      o_data.measured <= take;
      o_data.voltage <= prod[ADC_BITS +: bgp_pkg::MV_W];
    end
  end

endmodule

/* hw/rtl/bgp_segment.sv */
// Breakpoint segment selection and the interpolation product.
module bgp_segment #(
  parameter int NUM_BREAKPOINTS = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             i_valid,
  output logic             i_ready,
  input  bgp_pkg::sample_t i_data,
  input  bgp_pkg::mv_t     full_mv,
  input  bgp_pkg::mv_t     empty_mv,
  output logic             o_valid,
  input  logic             o_ready,
  output bgp_pkg::div_t    o_data
);

  localparam int NB = NUM_BREAKPOINTS;

  bgp_pkg::pct_t bp_pct [NB];
  bgp_pkg::mv_t  bp_mv [NB];
  bgp_pkg::seg_t seg_next;
  bgp_pkg::seg_t seg_q;
  logic          seg_valid;
  logic          seg_ready;

  for (genvar g = 0; g < NB; g++) begin : g_bp
    localparam int PCT = 100 - (100 * g) / (NB - 1);
    assign bp_pct[g] = bgp_pkg::PCT_W'(PCT);
    if (g == 0) begin : g_top
      assign bp_mv[g] = full_mv;
    end else if (g == NB - 1) begin : g_bottom
      assign bp_mv[g] = empty_mv;
    end else begin : g_mid
      assign bp_mv[g] = bgp_pkg::INTERIOR_MV[(g - 1) % bgp_pkg::MAX_BP];
    end
  end

  always_comb begin
    logic         found;
    bgp_pkg::mv_t v;
    found = 1'b0;
    v = i_data.voltage;
    seg_next.smp = i_data;
    seg_next.base_pct = '0;
    seg_next.delta = '0;
    seg_next.step_pct = '0;
    seg_next.span = bgp_pkg::MV_W'(1);
    if (v >= full_mv) begin
      seg_next.base_pct = bgp_pkg::FULL_PCT;
    end else if (v > empty_mv) begin
      for (int i = 1; i < NB; i++) begin
        if (!found && v > bp_mv[i]) begin
          found = 1'b1;
          if (v >= bp_mv[i-1]) begin
            seg_next.base_pct = bp_pct[i-1];
          end else begin
            seg_next.base_pct = bp_pct[i];
            seg_next.delta = v - bp_mv[i];
            seg_next.span = bp_mv[i-1] - bp_mv[i];
            seg_next.step_pct = bp_pct[i-1] - bp_pct[i];
          end
        end
      end
    end
  end

  assign seg_ready = !o_valid || o_ready;
  assign i_ready = !seg_valid || seg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (i_ready) begin
        seg_valid <= i_valid;
      end
      if (seg_ready) begin
        o_valid <= seg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      seg_q <= seg_next;
    end
    if (seg_valid && seg_ready) begin
      o_data.smp <= seg_q.smp;
      o_data.base_pct <= seg_q.base_pct;
      o_data.rem <= bgp_pkg::NUM_W'(seg_q.delta) * bgp_pkg::NUM_W'(seg_q.step_pct);
      o_data.span <= seg_q.span;
      o_data.quo <= '0;
    end
  end

endmodule

/* hw/rtl/bgp_div_step.sv */
// One restoring division step that settles one quotient bit.
module bgp_div_step #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          i_valid,
  output logic          i_ready,
  input  bgp_pkg::div_t i_data,
  output logic          o_valid,
  input  logic          o_ready,
  output bgp_pkg::div_t o_data
);

  logic [bgp_pkg::NUM_W-1:0] divisor;
  logic                      fits;
  bgp_pkg::div_t             step_next;

  assign divisor = bgp_pkg::NUM_W'(i_data.span) << SHIFT;
  assign fits = i_data.rem >= divisor;

  always_comb begin
    step_next = i_data;
    if (fits) begin
      step_next.rem = i_data.rem - divisor;
      step_next.quo[SHIFT] = 1'b1;
    end
  end

  assign i_ready = !o_valid || o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (i_ready) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      o_data <= step_next;
    end
  end

endmodule

/* hw/rtl/battery_gauge_piecewise_percent.sv */
// Top level of the piecewise-linear battery gauge.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    now_time, adc_sample
//   out      output     out_valid / out_ready  percent, voltage_mv, low_flag, measured
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is taken every cycle unless a stall on the output has filled the pipeline.
// The stages are the input register, the millivolt product, the segment choice,
// the interpolation product, seven quotient-bit steps and the result register.
// Each stage holds its word while the one after it is full, so a stall on the
// output only fills the pipeline. Reset is synchronous; cfg_ready is always high.
module battery_gauge_piecewise_percent #(
  parameter int NUM_BREAKPOINTS = 11,
  parameter int ADC_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bgp_pkg::TIME_W-1:0]        now_time,
  input  logic [ADC_BITS-1:0]               adc_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bgp_pkg::PCT_W-1:0]         percent,
  output logic [bgp_pkg::MV_W-1:0]          voltage_mv,
  output logic                              low_flag,
  output logic                              measured,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgp_pkg::INTERVAL_W-1:0]    cfg_data
);

  localparam int QW = bgp_pkg::QUO_W;

  logic [bgp_pkg::INTERVAL_W-1:0] check_interval;
  bgp_pkg::mv_t                   low_threshold_mv;
  bgp_pkg::mv_t                   full_mv;
  bgp_pkg::mv_t                   empty_mv;
  bgp_pkg::mv_t                   held_voltage;
  bgp_pkg::pct_t                  held_percent;

  logic             smp_valid;
  logic             smp_ready;
  bgp_pkg::sample_t smp_data;

  logic             dv_valid [QW+1];
  logic             dv_ready [QW+1];
  bgp_pkg::div_t    dv_data [QW+1];

  logic             last_ready;
  bgp_pkg::div_t    last;
  bgp_pkg::pct_t    pct_new;
  bgp_pkg::pct_t    percent_next;
  bgp_pkg::mv_t     voltage_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_interval <= bgp_pkg::RESET_INTERVAL;
      low_threshold_mv <= bgp_pkg::RESET_LOW_MV;
      full_mv <= bgp_pkg::RESET_FULL_MV;
      empty_mv <= bgp_pkg::RESET_EMPTY_MV;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bgp_pkg::CFG_CHECK_INTERVAL: check_interval <= cfg_data;
        bgp_pkg::CFG_LOW_THRESHOLD:  low_threshold_mv <= cfg_data[bgp_pkg::MV_W-1:0];
        bgp_pkg::CFG_FULL:           full_mv <= cfg_data[bgp_pkg::MV_W-1:0];
        bgp_pkg::CFG_EMPTY:          empty_mv <= cfg_data[bgp_pkg::MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bgp_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_time      (now_time),
    .adc_sample    (adc_sample),
    .check_interval(check_interval),
    .o_valid       (smp_valid),
    .o_ready       (smp_ready),
    .o_data        (smp_data)
  );

  bgp_segment #(
    .NUM_BREAKPOINTS(NUM_BREAKPOINTS)
  ) u_segment (
    .clk     (clk),
    .rst     (rst),
    .i_valid (smp_valid),
    .i_ready (smp_ready),
    .i_data  (smp_data),
    .full_mv (full_mv),
    .empty_mv(empty_mv),
    .o_valid (dv_valid[0]),
    .o_ready (dv_ready[0]),
    .o_data  (dv_data[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    bgp_div_step #(
      .SHIFT(QW - 1 - k)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .i_valid(dv_valid[k]),
      .i_ready(dv_ready[k]),
      .i_data (dv_data[k]),
      .o_valid(dv_valid[k+1]),
      .o_ready(dv_ready[k+1]),
      .o_data (dv_data[k+1])
    );
  end

  assign last = dv_data[QW];
  assign last_ready = !out_valid || out_ready;
  assign dv_ready[QW] = last_ready;
  assign pct_new = last.base_pct + bgp_pkg::PCT_W'(last.quo);
  assign percent_next = last.smp.measured ? pct_new : held_percent;
  assign voltage_next = last.smp.measured ? last.smp.voltage : held_voltage;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_percent <= bgp_pkg::FULL_PCT;
      held_voltage <= bgp_pkg::RESET_FULL_MV;
    end else begin
      if (last_ready) begin
        out_valid <= dv_valid[QW];
      end
      if (dv_valid[QW] && last_ready) begin
        held_percent <= percent_next;
        held_voltage <= voltage_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_valid[QW] && last_ready) begin
      percent <= percent_next;
      voltage_mv <= voltage_next;
      low_flag <= voltage_next < low_threshold_mv;
      measured <= last.smp.measured;
    end
  end

`ifndef NO_ASSERTIONS
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> percent <= bgp_pkg::FULL_PCT)
    else $error("percent above full scale");

  a_full_pct: assert property (@(posedge clk) disable iff (rst)
    out_valid && measured && voltage_mv >= full_mv |-> percent == bgp_pkg::FULL_PCT)
    else $error("voltage at or above full did not give full percent");

  a_empty_pct: assert property (@(posedge clk) disable iff (rst)
    out_valid && measured && voltage_mv < full_mv && voltage_mv <= empty_mv
      |-> percent == '0)
    else $error("voltage at or below empty did not give zero percent");
`endif

endmodule
